// ===== rtl/core/dxtbd_pkg.sv =====
`timescale 1ns / 1ps

package dxtbd_pkg;

  // Image limits and field widths
  localparam int MAX_DIM = 2048;
  localparam int DIM_W   = 12;   // width of image_width / image_height
  localparam int POS_W   = 11;   // pixel coordinate width
  localparam int BLK_W   = 9;    // block index width

  // Block format codes
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_FORMAT = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  // Reciprocals for truncating division by constants
  localparam logic [9:0]  RECIP3 = 10'd683;   // /3 over 0..765,  >> 11
  localparam logic [10:0] RECIP5 = 11'd1639;  // /5 over 0..1275, >> 13
  localparam logic [11:0] RECIP7 = 12'd2341;  // /7 over 0..1785, >> 14

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } bgr_t;

  function automatic bgr_t expand565(input logic [15:0] c);
    bgr_t o;
    o.r = {c[15:11], c[15:13]};
    o.g = {c[10:5], c[10:9]};
    o.b = {c[4:0], c[4:2]};
    return o;
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [19:0] p;
    p = 20'(v) * 20'(RECIP3);
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] v);
    logic [20:0] p;
    p = 21'(v) * 21'(RECIP5);
    return p[20:13];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] v);
    logic [21:0] p;
    p = 22'(v) * 22'(RECIP7);
    return p[21:14];
  endfunction

endpackage

// ===== rtl/core/dxt_block_decoder_core.sv =====
`timescale 1ns / 1ps

// DXT1/DXT3/DXT5 4x4 block decoder.
// Input: a transaction is taken at a clock edge with start high and busy low;
// it carries the 16-byte block (lo/hi words) and the block column and row.
// Config: cfg_valid/cfg_ready write channel, cfg_index selects format (0),
// image width (1) or image height (2); cfg_ready is always high. Write only
// while the decoder is idle.
// Output: one BGRA pixel per out_valid strobe, row-major inside the block,
// clipped to the image size; out_last_pixel marks the block's final pixel.
// The receiver has no backpressure: every strobe is a completed transaction.
// Path: the first pixel of a block passes the input register, then the palette
// register, then the output register; the palette register waits for a free walker.
// Throughput: one pixel per cycle while the pixel walker holds a block. A block
// occupies the walker until its visible pixels (16 for an unclipped block) are out; a
// block with no visible pixel is dropped at the input register and emits nothing. The
// input register accepts the next block while the current one is walked,
// so visible blocks stream with no gaps between them.
// Reset: format DXT1, width and height 2048, pipeline emptied.
module dxt_block_decoder_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [63:0]                 in_block_word_lo,
  input  logic [63:0]                 in_block_word_hi,
  input  logic [dxtbd_pkg::BLK_W-1:0] in_block_col,
  input  logic [dxtbd_pkg::BLK_W-1:0] in_block_row,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [dxtbd_pkg::DIM_W-1:0] cfg_data,
  output logic                        out_valid,
  output logic [dxtbd_pkg::POS_W-1:0] out_pixel_x,
  output logic [dxtbd_pkg::POS_W-1:0] out_pixel_y,
  output logic [7:0]                  out_blue,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_alpha,
  output logic                        out_last_pixel
);
  import dxtbd_pkg::*;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [1:0]       cfg_fmt_r;
  logic [DIM_W-1:0] cfg_w_r;
  logic [DIM_W-1:0] cfg_h_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_fmt_r <= FMT_DXT1;
      cfg_w_r   <= DIM_W'(MAX_DIM);
      cfg_h_r   <= DIM_W'(MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FORMAT: cfg_fmt_r <= cfg_data[1:0];
        CFG_WIDTH:  cfg_w_r   <= cfg_data;
        CFG_HEIGHT: cfg_h_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------
  logic             s1_valid_r;
  logic [63:0]      s1_lo_r;
  logic [63:0]      s1_hi_r;
  logic [BLK_W-1:0] s1_col_r;
  logic [BLK_W-1:0] s1_row_r;

  // Stage 2: palette register and pixel walker
  logic             s2_valid_r;
  logic [1:0]       s2_fmt_r;
  logic [63:0]      s2_lo_r;
  logic [31:0]      s2_idx_r;
  bgr_t             s2_pal_r [4];
  logic             s2_three_r;   // DXT1 three-color mode
  logic [7:0]       s2_apal_r [8];
  logic [BLK_W-1:0] s2_col_r;
  logic [BLK_W-1:0] s2_row_r;
  logic [2:0]       s2_ncols_r;
  logic [2:0]       s2_nrows_r;
  logic [1:0]       s2_lx_r;
  logic [1:0]       s2_ly_r;

  logic s2_row_end;
  logic s2_last;
  logic s2_free;
  logic in_acc;

  assign s2_row_end = ({1'b0, s2_lx_r} == s2_ncols_r - 3'd1);
  assign s2_last    = s2_row_end && ({1'b0, s2_ly_r} == s2_nrows_r - 3'd1);
  assign s2_free    = !s2_valid_r || s2_last;
  assign busy       = s1_valid_r && !s2_free;
  assign in_acc     = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s2_free) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_lo_r  <= in_block_word_lo;
      s1_hi_r  <= in_block_word_hi;
      s1_col_r <= in_block_col;
      s1_row_r <= in_block_row;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1 -> 2: palette build and clip extent
  // ---------------------------------------------------------------
  logic [1:0]       fmt_eff;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [DIM_W-1:0] col4;
  logic [DIM_W-1:0] row4;
  logic [DIM_W-1:0] wdiff;
  logic [DIM_W-1:0] hdiff;
  logic [2:0]       ncols_nxt;
  logic [2:0]       nrows_nxt;
  logic             s2_load;

  logic [63:0]      cblk;
  logic [15:0]      c0;
  logic [15:0]      c1;
  logic             three_nxt;
  bgr_t             p0;
  bgr_t             p1;
  bgr_t             pal_nxt [4];
  logic [7:0]       a0;
  logic [7:0]       a1;
  logic [7:0]       apal_nxt [8];

  always_comb begin
    fmt_eff = (cfg_fmt_r == FMT_DXT3 || cfg_fmt_r == FMT_DXT5) ? cfg_fmt_r : FMT_DXT1;
    w_eff   = (cfg_w_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_w_r;
    h_eff   = (cfg_h_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_h_r;
    col4    = {1'b0, s1_col_r, 2'b00};
    row4    = {1'b0, s1_row_r, 2'b00};
    wdiff   = w_eff - col4;
    hdiff   = h_eff - row4;

    // visible columns / rows of this block: 0..4
    if (w_eff <= col4)              ncols_nxt = 3'd0;
    else if (wdiff >= DIM_W'(4))    ncols_nxt = 3'd4;
    else                            ncols_nxt = wdiff[2:0];
    if (h_eff <= row4)              nrows_nxt = 3'd0;
    else if (hdiff >= DIM_W'(4))    nrows_nxt = 3'd4;
    else                            nrows_nxt = hdiff[2:0];
  end

  // fully clipped blocks are dropped here
  assign s2_load = s1_valid_r && s2_free && (ncols_nxt != 3'd0) && (nrows_nxt != 3'd0);

  // color palette
  always_comb begin
    cblk      = (fmt_eff == FMT_DXT1) ? s1_lo_r : s1_hi_r;
    c0        = cblk[15:0];
    c1        = cblk[31:16];
    three_nxt = (fmt_eff == FMT_DXT1) && (c0 <= c1);
    p0        = expand565(c0);
    p1        = expand565(c1);
    pal_nxt[0] = p0;
    pal_nxt[1] = p1;
    if (three_nxt) begin
      pal_nxt[2].b = 8'((10'(p0.b) + 10'(p1.b)) >> 1);
      pal_nxt[2].g = 8'((10'(p0.g) + 10'(p1.g)) >> 1);
      pal_nxt[2].r = 8'((10'(p0.r) + 10'(p1.r)) >> 1);
      pal_nxt[3]   = '0;
    end else begin
      pal_nxt[2].b = div3({1'b0, p0.b, 1'b0} + 10'(p1.b));
      pal_nxt[2].g = div3({1'b0, p0.g, 1'b0} + 10'(p1.g));
      pal_nxt[2].r = div3({1'b0, p0.r, 1'b0} + 10'(p1.r));
      pal_nxt[3].b = div3(10'(p0.b) + {1'b0, p1.b, 1'b0});
      pal_nxt[3].g = div3(10'(p0.g) + {1'b0, p1.g, 1'b0});
      pal_nxt[3].r = div3(10'(p0.r) + {1'b0, p1.r, 1'b0});
    end
  end

  // DXT5 alpha palette; weights are constants per entry
  always_comb begin
    a0 = s1_lo_r[7:0];
    a1 = s1_lo_r[15:8];
    apal_nxt[0] = a0;
    apal_nxt[1] = a1;
    for (int k = 1; k <= 6; k++) begin
      if (a0 > a1) begin
        apal_nxt[k+1] = div7(11'(a0) * 11'(7 - k) + 11'(a1) * 11'(k));
      end else if (k <= 4) begin
        apal_nxt[k+1] = div5(11'(a0) * 11'(5 - k) + 11'(a1) * 11'(k));
      end else if (k == 5) begin
        apal_nxt[k+1] = 8'd0;
      end else begin
        apal_nxt[k+1] = 8'd255;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_lx_r    <= 2'd0;
      s2_ly_r    <= 2'd0;
    end else if (s2_load) begin
      s2_valid_r <= 1'b1;
      s2_lx_r    <= 2'd0;
      s2_ly_r    <= 2'd0;
    end else if (s2_valid_r) begin
      if (s2_last) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_row_end) begin
        s2_lx_r <= 2'd0;
        s2_ly_r <= s2_ly_r + 2'd1;
      end else begin
        s2_lx_r <= s2_lx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_fmt_r   <= fmt_eff;
      s2_lo_r    <= s1_lo_r;
      s2_idx_r   <= cblk[63:32];
      s2_pal_r   <= pal_nxt;
      s2_three_r <= three_nxt;
      s2_apal_r  <= apal_nxt;
      s2_col_r   <= s1_col_r;
      s2_row_r   <= s1_row_r;
      s2_ncols_r <= ncols_nxt;
      s2_nrows_r <= nrows_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2 -> output: per-pixel lookup
  // ---------------------------------------------------------------
  logic [3:0] loc;
  logic [1:0] ci;
  logic [3:0] nib;
  logic [5:0] abit;
  logic [7:0] alpha_nxt;
  bgr_t       px_color;

  always_comb begin
    loc      = {s2_ly_r, s2_lx_r};
    ci       = s2_idx_r[{loc, 1'b0} +: 2];
    px_color = s2_pal_r[ci];
    nib      = s2_lo_r[{loc, 2'b00} +: 4];
    abit     = 6'd16 + 6'(loc) * 6'd3;
    case (s2_fmt_r)
      FMT_DXT3: alpha_nxt = {nib, nib};
      FMT_DXT5: alpha_nxt = s2_apal_r[s2_lo_r[abit +: 3]];
      default:  alpha_nxt = (s2_three_r && ci == 2'd3) ? 8'd0 : 8'd255;
    endcase
  end

  logic             out_valid_r;
  logic [POS_W-1:0] out_x_r;
  logic [POS_W-1:0] out_y_r;
  bgr_t             out_color_r;
  logic [7:0]       out_alpha_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      out_x_r     <= {s2_col_r, s2_lx_r};
      out_y_r     <= {s2_row_r, s2_ly_r};
      out_color_r <= px_color;
      out_alpha_r <= alpha_nxt;
      out_last_r  <= s2_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = out_x_r;
  assign out_pixel_y    = out_y_r;
  assign out_blue       = out_color_r.b;
  assign out_green      = out_color_r.g;
  assign out_red        = out_color_r.r;
  assign out_alpha      = out_alpha_r;
  assign out_last_pixel = out_last_r;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

// Block decoder testbench. Blocks go in through the start/busy command port,
// pixels come back one per out_valid strobe with no backpressure.
module tb;
  import dxtbd_pkg::*;

  // Format code three is not a real format; the decoder treats it as DXT1.
  localparam logic [1:0] FMT_CODE3 = 2'd3;
  localparam logic [DIM_W-1:0] FULL_DIM = DIM_W'(MAX_DIM);

  typedef struct {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [7:0]       b;
    logic [7:0]       g;
    logic [7:0]       r;
    logic [7:0]       a;
    logic             last;
  } pixel_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [63:0]      in_block_word_lo;
  logic [63:0]      in_block_word_hi;
  logic [BLK_W-1:0] in_block_col;
  logic [BLK_W-1:0] in_block_row;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [DIM_W-1:0] cfg_data;
  logic             out_valid;
  logic [POS_W-1:0] out_pixel_x;
  logic [POS_W-1:0] out_pixel_y;
  logic [7:0]       out_blue;
  logic [7:0]       out_green;
  logic [7:0]       out_red;
  logic [7:0]       out_alpha;
  logic             out_last_pixel;

  // Shadow copy of the decoder's registers, updated when a write is taken.
  logic [1:0]       fmt_reg;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;

  // Pixels predicted for accepted blocks, oldest first.
  pixel_t pending_pixels[$];
  int     mismatch_count;

  dxt_block_decoder_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_block_word_lo(in_block_word_lo),
    .in_block_word_hi(in_block_word_hi),
    .in_block_col   (in_block_col),
    .in_block_row   (in_block_row),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_blue       (out_blue),
    .out_green      (out_green),
    .out_red        (out_red),
    .out_alpha      (out_alpha),
    .out_last_pixel (out_last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: the run fails if it has not finished before the timeout.
  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // RGB565 endpoint to 8-bit channels, low bits filled by replicating the top.
  function automatic void unpack_565(input logic [15:0] c, output int unsigned bl,
                                     output int unsigned gr, output int unsigned rd);
    bl = {c[4:0], c[4:2]};
    gr = {c[10:5], c[10:9]};
    rd = {c[15:11], c[15:13]};
  endfunction

  // Decode one block against the current register shadow and queue the
  // visible pixels in row-major order; the final one carries last.
  function automatic void decode_block(input logic [63:0] lo, input logic [63:0] hi,
                                       input logic [BLK_W-1:0] col,
                                       input logic [BLK_W-1:0] row);
    logic [1:0]  fmt;
    logic [63:0] cblk;
    logic [15:0] c0;
    logic [15:0] c1;
    logic [31:0] idx;
    logic [3:0]  nib;
    int unsigned w;
    int unsigned h;
    int unsigned pal[4][3];
    int unsigned pal_a[4];
    int unsigned apal[8];
    int unsigned a0;
    int unsigned a1;
    int unsigned px;
    int unsigned py;
    int unsigned loc;
    int unsigned ci;
    pixel_t      p;
    pixel_t      blk[$];

    fmt  = (fmt_reg == FMT_DXT3 || fmt_reg == FMT_DXT5) ? fmt_reg : FMT_DXT1;
    w    = (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
    h    = (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
    cblk = (fmt == FMT_DXT1) ? lo : hi;
    c0   = cblk[15:0];
    c1   = cblk[31:16];
    idx  = cblk[63:32];

    unpack_565(c0, pal[0][0], pal[0][1], pal[0][2]);
    unpack_565(c1, pal[1][0], pal[1][1], pal[1][2]);
    for (int k = 0; k < 4; k++) pal_a[k] = 255;
    if (fmt != FMT_DXT1 || c0 > c1) begin
      for (int k = 0; k < 3; k++) begin
        pal[2][k] = (2 * pal[0][k] + pal[1][k]) / 3;
        pal[3][k] = (pal[0][k] + 2 * pal[1][k]) / 3;
      end
    end else begin
      // three-color mode: midpoint, and index 3 is transparent black
      for (int k = 0; k < 3; k++) begin
        pal[2][k] = (pal[0][k] + pal[1][k]) / 2;
        pal[3][k] = 0;
      end
      pal_a[3] = 0;
    end

    a0 = lo[7:0];
    a1 = lo[15:8];
    apal[0] = a0;
    apal[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k <= 6; k++) apal[k + 1] = ((7 - k) * a0 + k * a1) / 7;
    end else begin
      for (int k = 1; k <= 4; k++) apal[k + 1] = ((5 - k) * a0 + k * a1) / 5;
      apal[6] = 0;
      apal[7] = 255;
    end

    for (int y = 0; y < 4; y++) begin
      py = row * 4 + y;
      if (py >= h) break;
      for (int x = 0; x < 4; x++) begin
        px  = col * 4 + x;
        loc = y * 4 + x;
        ci  = idx[2 * loc +: 2];
        if (px >= w) continue;
        p.x    = POS_W'(px);
        p.y    = POS_W'(py);
        p.b    = 8'(pal[ci][0]);
        p.g    = 8'(pal[ci][1]);
        p.r    = 8'(pal[ci][2]);
        p.last = 1'b0;
        if (fmt == FMT_DXT3) begin
          nib = lo[4 * loc +: 4];
          p.a = {nib, nib};
        end else if (fmt == FMT_DXT5) begin
          p.a = 8'(apal[lo[16 + 3 * loc +: 3]]);
        end else begin
          p.a = 8'(pal_a[ci]);
        end
        blk.push_back(p);
      end
    end
    if (blk.size() > 0) blk[blk.size() - 1].last = 1'b1;
    foreach (blk[i]) pending_pixels.push_back(blk[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking: every strobe is a finished transaction, sampled at the edge
  // that ends its cycle.
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t tb: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t tb: unexpected pixel x=%0d y=%0d", $time, out_pixel_x, out_pixel_y);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", want.x, out_pixel_x);
        check_field("pixel_y", want.y, out_pixel_y);
        check_field("blue", want.b, out_blue);
        check_field("green", want.g, out_green);
        check_field("red", want.r, out_red);
        check_field("alpha", want.a, out_alpha);
        check_field("last_pixel", want.last, out_last_pixel);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task starts and ends right after a rising edge; start is
  // left high between back-to-back blocks and only dropped by an idle.
  // ---------------------------------------------------------------------------

  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [BLK_W-1:0] col, input logic [BLK_W-1:0] row);
    in_block_word_lo <= lo;
    in_block_word_hi <= hi;
    in_block_col     <= col;
    in_block_row     <= row;
    start            <= 1'b1;
    do @(posedge clk); while (busy);
    decode_block(lo, hi, col, row);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Wait until every predicted pixel is out, then give a fully clipped
  // block (no pixels, so nothing to wait on) time to leave the pipeline.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FORMAT: fmt_reg    = val[1:0];
      CFG_WIDTH:  width_reg  = val;
      CFG_HEIGHT: height_reg = val;
      default: ;
    endcase
  endtask

  // Registers only change with the decoder idle.
  task automatic set_config(input logic [1:0] fmt, input logic [DIM_W-1:0] w,
                            input logic [DIM_W-1:0] h);
    drain_pipeline();
    cfg_valid <= 1'b1;
    put_reg(CFG_FORMAT, {{(DIM_W-2){1'b0}}, fmt});
    put_reg(CFG_WIDTH, w);
    put_reg(CFG_HEIGHT, h);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Dimension for a random phase: extremes, oversized values, mostly small.
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 7))
      0:       return DIM_W'(1);
      1:       return FULL_DIM;
      2:       return DIM_W'(4095);
      3:       return DIM_W'($urandom_range(MAX_DIM + 1, 4095));
      default: return DIM_W'($urandom_range(1, 64));
    endcase
  endfunction

  // Block index: mostly inside the image or just past its edge, so clipping happens often.
  function automatic logic [BLK_W-1:0] pick_coord(input logic [DIM_W-1:0] dim);
    int unsigned lim;
    lim = ((dim > MAX_DIM ? MAX_DIM : dim) + 3) / 4;
    if (lim > 511) lim = 511;
    if ($urandom_range(0, 3) == 0) return BLK_W'($urandom_range(0, 511));
    return BLK_W'($urandom_range(0, lim));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: DXT1, 2048 x 2048.
  task automatic test_dxt1_palettes();
    send_block(64'h0, 64'h0, 9'd0, 9'd0);
    // c0 = c1 = all ones: three-color mode, every index is 3 (transparent)
    send_block({64{1'b1}}, {64{1'b1}}, 9'd511, 9'd511);
    // four-color mode, indices 0..3 in every row
    send_block({32'hE4E4E4E4, 16'h07E0, 16'hF81F}, rand64(), 9'd3, 9'd7);
    // three-color mode, c0 < c1
    send_block({32'hE4E4E4E4, 16'hF81F, 16'h07E0}, rand64(), 9'd100, 9'd200);
    // equal endpoints fall into three-color mode too
    send_block({32'h1B1B1B1B, 16'h8410, 16'h8410}, rand64(), 9'd1, 9'd0);
  endtask

  task automatic test_dxt3_alpha();
    set_config(FMT_DXT3, FULL_DIM, FULL_DIM);
    send_block(64'h0123456789ABCDEF, {32'hE4E4E4E4, 16'h001F, 16'hFFE0}, 9'd5, 9'd5);
    // c0 < c1 still interpolates in four-color mode outside DXT1
    send_block({64{1'b1}}, {32'hFFFF0000, 16'hFFFF, 16'h0000}, 9'd0, 9'd1);
  endtask

  task automatic test_dxt5_alpha();
    set_config(FMT_DXT5, FULL_DIM, FULL_DIM);
    // alpha codes 0..7 twice over, eight-entry palette
    send_block({48'hFAC688FAC688, 8'h10, 8'hF0}, {32'hE4E4E4E4, 16'h0000, 16'hFFFF},
               9'd2, 9'd3);
    // six-entry palette with fixed 0 and 255
    send_block({48'hFAC688FAC688, 8'hF0, 8'h10}, {32'h1B1B1B1B, 16'hFFFF, 16'h0000},
               9'd4, 9'd4);
    send_block({48'hFAC688FAC688, 8'h80, 8'h80}, rand64(), 9'd6, 9'd6);
  endtask

  task automatic test_format_code_three();
    set_config(FMT_CODE3, FULL_DIM, FULL_DIM);
    send_block({32'hE4E4E4E4, 16'hF81F, 16'h07E0}, rand64(), 9'd9, 9'd9);
  endtask

  task automatic test_clipping();
    // partial block on the right and bottom edges, then blocks fully outside
    set_config(FMT_DXT1, 12'd6, 12'd7);
    send_block(rand64(), rand64(), 9'd1, 9'd1);
    send_block(rand64(), rand64(), 9'd0, 9'd1);
    send_block(rand64(), rand64(), 9'd1, 9'd0);
    send_block(rand64(), rand64(), 9'd2, 9'd0);
    send_block(rand64(), rand64(), 9'd0, 9'd2);
    // zero width clips everything
    set_config(FMT_DXT5, 12'd0, FULL_DIM);
    send_block(rand64(), rand64(), 9'd0, 9'd0);
    // oversized dimensions clamp to the maximum
    set_config(FMT_DXT3, 12'd4095, 12'd4095);
    send_block(rand64(), rand64(), 9'd511, 9'd511);
    set_config(FMT_DXT1, 12'd2047, 12'd1);
    send_block(rand64(), rand64(), 9'd511, 9'd0);
    // single-pixel image
    set_config(FMT_DXT1, 12'd1, 12'd1);
    send_block(rand64(), rand64(), 9'd0, 9'd0);
  endtask

  // Random blocks in several register phases; the last phase streams
  // back to back with no sender gaps.
  task automatic test_random_stream();
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    for (int phase = 0; phase < 5; phase++) begin
      w = (phase == 0) ? FULL_DIM : pick_dim();
      h = (phase == 0) ? FULL_DIM : pick_dim();
      set_config(2'($urandom_range(0, 3)), w, h);
      for (int n = 0; n < 40; n++) begin
        send_block(rand64(), rand64(), pick_coord(w), pick_coord(h));
        if (phase < 4 && $urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 9));
      end
    end
  endtask

  initial begin
    mismatch_count   = 0;
    fmt_reg          = FMT_DXT1;
    width_reg        = FULL_DIM;
    height_reg       = FULL_DIM;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_block_word_lo <= '0;
    in_block_word_hi <= '0;
    in_block_col     <= '0;
    in_block_row     <= '0;
    cfg_valid        <= 1'b0;
    cfg_index        <= CFG_FORMAT;
    cfg_data         <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_dxt1_palettes();
    test_dxt3_alpha();
    test_dxt5_alpha();
    test_format_code_three();
    test_clipping();
    test_random_stream();

    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
